>>> rtl/rts_pkg.sv
// Round-trip statistics package: item structs, widths, sequencer states.
// No dependencies; used by round_trip_statistics_top.
package rts_pkg;

    // Fixed field widths of the item payloads
    localparam int SAMPLE_W = 24;
    localparam int MEAN_OUT_W = 32;
    localparam int DEV_OUT_W = 32;
    localparam int COUNT_OUT_W = 16;

    // Sizing of the datapath
    localparam int SAMPLE_BITS = 24;   // 8..24 significant sample bits
    localparam int COUNT_BITS = 16;    // 4..16 counter bits

    localparam int SQ_BITS = 2 * SAMPLE_BITS;                // one squared sample
    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;         // running sum
    localparam int SUMSQ_W = SQ_BITS + COUNT_BITS;           // running sum of squares
    localparam int X_W = 2 * SUM_W;                          // n*sumsq - sum^2
    localparam int DSQ_W = 2 * COUNT_BITS;                   // n*n
    localparam int DVD_W = X_W + 16;                         // dividend, Q16 scaled
    localparam int RAD_W = 2 * SAMPLE_BITS + 16;             // sqrt radicand
    localparam int ROOT_W = RAD_W / 2;                       // sqrt result
    localparam int MEAN_W = SAMPLE_BITS + 8;                 // mean quotient kept
    localparam int CNT_W = $clog2(DVD_W + 1);                // step counter

    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_us;
        logic                last;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0]    min_us;
        logic [SAMPLE_W-1:0]    max_us;
        logic [MEAN_OUT_W-1:0]  mean_q8;
        logic [DEV_OUT_W-1:0]   stddev_q8;
        logic [COUNT_OUT_W-1:0] sample_count;
        logic                   overflow;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_NN,
        S_P1,
        S_P2,
        S_VDIV,
        S_SQRT,
        S_MDIV,
        S_DONE
    } t_state;

endpackage

>>> rtl/round_trip_statistics_top.sv
// Round-trip statistics top level: accumulator, sequencer and shared
// bit-serial multiply / divide / square-root datapath. Depends on rts_pkg.
//
// Round-trip time statistics. Each input item carries one sample in whole
// microseconds and a last flag. For a sample without last, the item is
// accepted (the square is formed and registered) and the next cycle folds
// it into count, min, max, sum and sum of squares; ready returns in the
// cycle after that. An item with last is folded in the same way and then
// runs the one-bit-per-cycle sequence on the shared datapath: n*n, n*sumsq
// and sum^2 through one shift-add/subtract unit, then two restoring
// divides (variance and mean) and one restoring square root. The report
// item carries min, max, mean and population standard deviation (both Q8,
// truncated), the count and an overflow flag; all accumulators clear once
// the report is registered. Once the count saturates, further samples are
// dropped and overflow is set. The report sits in an output register, so
// the next item is taken while it waits; a later report waits for that
// register to empty.
module round_trip_statistics_top
    import rts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    // Sequencer
    t_state r_state, n_state;

    // Accepted sample, its square and flag
    logic [SAMPLE_BITS-1:0] r_samp;
    logic [SQ_BITS-1:0]     r_sq;
    logic                   r_last;

    // Batch accumulators
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [SAMPLE_W-1:0]   r_min, n_min;
    logic [SAMPLE_W-1:0]   r_max, n_max;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [SUMSQ_W-1:0]    r_sumsq, n_sumsq;
    logic                  r_dropped, n_dropped;

    // Shift-add multiplier
    logic [X_W-1:0]   r_ma, n_ma;
    logic [SUM_W-1:0] r_mb, n_mb;
    logic [X_W-1:0]   r_macc, n_macc;
    logic             r_msub, n_msub;
    logic [DSQ_W-1:0] r_dsq, n_dsq;

    // Divider and square root share the dividend shift register
    logic [DVD_W-1:0]  r_dvd, n_dvd;
    logic [DSQ_W-1:0]  r_dvs, n_dvs;
    logic [DSQ_W-1:0]  r_rem, n_rem;
    logic [ROOT_W+1:0] r_srem, n_srem;
    logic [ROOT_W-1:0] r_root, n_root;

    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Output register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    // Step results
    logic [X_W-1:0]    mul_step;
    logic [DSQ_W:0]    div_sh;
    logic              div_ge;
    logic [DSQ_W:0]    div_diff;
    logic [ROOT_W+1:0] sq_sh;
    logic [ROOT_W+1:0] sq_trial;
    logic              sq_ge;
    logic              last_step;
    logic              out_space;
    logic              drop;
    logic              accept;

    assign accept    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;
    assign out_space = !r_out_valid || i_out_ready;
    assign last_step = (r_cnt == CNT_W'(1));
    assign drop = (r_count == COUNT_LIMIT);

    always_comb begin
        if (r_mb[0]) begin
            mul_step = r_msub ? (r_macc - r_ma) : (r_macc + r_ma);
        end else begin
            mul_step = r_macc;
        end
        div_sh   = {r_rem, r_dvd[DVD_W-1]};
        div_ge   = (div_sh >= {1'b0, r_dvs});
        div_diff = div_sh - {1'b0, r_dvs};
        sq_sh    = {r_srem[ROOT_W-1:0], r_dvd[RAD_W-1 -: 2]};
        sq_trial = {r_root, 2'b01};
        sq_ge    = (sq_sh >= sq_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_dropped   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
            r_sum       <= n_sum;
            r_sumsq     <= n_sumsq;
            r_dropped   <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_samp <= i_in.sample_us[SAMPLE_BITS-1:0];
            r_sq   <= SQ_BITS'(i_in.sample_us[SAMPLE_BITS-1:0])
                      * SQ_BITS'(i_in.sample_us[SAMPLE_BITS-1:0]);
            r_last <= i_in.last;
        end
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_macc <= n_macc;
        r_msub <= n_msub;
        r_dsq  <= n_dsq;
        r_dvd  <= n_dvd;
        r_dvs  <= n_dvs;
        r_rem  <= n_rem;
        r_srem <= n_srem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_sum       = r_sum;
        n_sumsq     = r_sumsq;
        n_dropped   = r_dropped;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_macc      = r_macc;
        n_msub      = r_msub;
        n_dsq       = r_dsq;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_rem       = r_rem;
        n_srem      = r_srem;
        n_root      = r_root;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (drop) begin
                    n_dropped = 1'b1;
                end else begin
                    n_count = r_count + 1'b1;
                    if (SAMPLE_W'(r_samp) < r_min) begin
                        n_min = SAMPLE_W'(r_samp);
                    end
                    if (SAMPLE_W'(r_samp) > r_max) begin
                        n_max = SAMPLE_W'(r_samp);
                    end
                    n_sum   = r_sum + SUM_W'(r_samp);
                    n_sumsq = r_sumsq + SUMSQ_W'(r_sq);
                end
                if (r_last) begin
                    // n*n first: it becomes the variance divisor
                    n_ma    = X_W'(n_count);
                    n_mb    = SUM_W'(n_count);
                    n_macc  = '0;
                    n_msub  = 1'b0;
                    n_cnt   = CNT_W'(COUNT_BITS);
                    n_state = S_NN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_NN: begin
                n_macc = mul_step;
                n_ma   = r_ma << 1;
                n_mb   = r_mb >> 1;
                n_cnt  = r_cnt - 1'b1;
                if (last_step) begin
                    n_dsq   = mul_step[DSQ_W-1:0];
                    n_ma    = X_W'(r_sumsq);
                    n_mb    = SUM_W'(r_count);
                    n_macc  = '0;
                    n_cnt   = CNT_W'(COUNT_BITS);
                    n_state = S_P1;
                end
            end
            S_P1: begin
                n_macc = mul_step;
                n_ma   = r_ma << 1;
                n_mb   = r_mb >> 1;
                n_cnt  = r_cnt - 1'b1;
                if (last_step) begin
                    // subtract sum^2 from n*sumsq in place
                    n_ma    = X_W'(r_sum);
                    n_mb    = r_sum;
                    n_msub  = 1'b1;
                    n_cnt   = CNT_W'(SUM_W);
                    n_state = S_P2;
                end
            end
            S_P2: begin
                n_macc = mul_step;
                n_ma   = r_ma << 1;
                n_mb   = r_mb >> 1;
                n_cnt  = r_cnt - 1'b1;
                if (last_step) begin
                    n_dvd   = {mul_step, 16'h0000};
                    n_dvs   = r_dsq;
                    n_rem   = '0;
                    n_cnt   = CNT_W'(DVD_W);
                    n_state = S_VDIV;
                end
            end
            S_VDIV: begin
                n_rem = div_ge ? div_diff[DSQ_W-1:0] : div_sh[DSQ_W-1:0];
                n_dvd = {r_dvd[DVD_W-2:0], div_ge};
                n_cnt = r_cnt - 1'b1;
                if (last_step) begin
                    n_srem  = '0;
                    n_root  = '0;
                    n_cnt   = CNT_W'(ROOT_W);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                // two radicand bits per step from the low quotient window
                n_srem = sq_ge ? (sq_sh - sq_trial) : sq_sh;
                n_root = {r_root[ROOT_W-2:0], sq_ge};
                n_dvd  = r_dvd << 2;
                n_cnt  = r_cnt - 1'b1;
                if (last_step) begin
                    n_dvd   = DVD_W'({r_sum, 8'h00});
                    n_dvs   = DSQ_W'(r_count);
                    n_rem   = '0;
                    n_cnt   = CNT_W'(DVD_W);
                    n_state = S_MDIV;
                end
            end
            S_MDIV: begin
                n_rem = div_ge ? div_diff[DSQ_W-1:0] : div_sh[DSQ_W-1:0];
                n_dvd = {r_dvd[DVD_W-2:0], div_ge};
                n_cnt = r_cnt - 1'b1;
                if (last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_space) begin
                    n_out_valid        = 1'b1;
                    n_out.min_us       = r_min;
                    n_out.max_us       = r_max;
                    n_out.sample_count = COUNT_OUT_W'(r_count);
                    n_out.overflow     = r_dropped;
                    if (r_count == '0) begin
                        n_out.mean_q8   = '0;
                        n_out.stddev_q8 = '0;
                    end else begin
                        n_out.mean_q8   = MEAN_OUT_W'(r_dvd[MEAN_W-1:0]);
                        n_out.stddev_q8 = DEV_OUT_W'(r_root);
                    end
                    // clear the batch
                    n_count   = '0;
                    n_min     = '1;
                    n_max     = '0;
                    n_sum     = '0;
                    n_sumsq   = '0;
                    n_dropped = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Samples are dropped only once the count has saturated
    a_drop_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropped |-> (r_count == COUNT_LIMIT))
        else $error("dropped set with unsaturated count");

    // A nonempty batch always has min <= max
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_min <= r_max))
        else $error("running min above running max");

    // A report appears only out of the final sequencer state
    a_rep_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> (r_state == S_DONE))
        else $error("report raised outside final state");

    // After a report is registered the batch is clear
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_space) |=> (r_count == '0 && !r_dropped))
        else $error("batch not cleared after report");

    // Every report counts at least one sample
    a_rep_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.sample_count != '0))
        else $error("report with zero samples");

endmodule

>>> tb/sv/round_trip_statistics_checker.sv
`timescale 1ns / 1ps
// Checker for round_trip_statistics_top: watches both item channels, keeps its own
// batch accumulators, predicts each report and compares it field by field. Uses rts_pkg.
module round_trip_statistics_checker
    import rts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out,
    input  logic      i_end_check,
    output int        o_pending,
    output int        o_errors,
    output int        o_reports
);

    logic [COUNT_BITS-1:0]  batch_n;
    logic [SAMPLE_BITS-1:0] batch_min;
    logic [SAMPLE_BITS-1:0] batch_max;
    logic [SUM_W-1:0]       batch_sum;
    logic [SUMSQ_W-1:0]     batch_sumsq;
    logic                   batch_dropped;

    t_out_item expected_reports[$];

    initial begin
        o_pending = 0;
        o_errors  = 0;
        o_reports = 0;
    end

    task automatic clear_batch();
        batch_n       = '0;
        batch_min     = '1;
        batch_max     = '0;
        batch_sum     = '0;
        batch_sumsq   = '0;
        batch_dropped = 1'b0;
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("ERROR %0t ns: %s got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    // floor(sqrt(x)), one result bit per step from the top
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Report for the batch held in the accumulators
    function automatic t_out_item batch_report();
        logic [127:0] n_sumsq;
        logic [127:0] sum_sq;
        logic [127:0] scaled;
        logic [63:0]  var_q16;
        logic [47:0]  mean_full;
        t_out_item    rep;
        rep = '0;
        rep.min_us       = batch_min;
        rep.max_us       = batch_max;
        rep.sample_count = batch_n;
        rep.overflow     = batch_dropped;
        if (batch_n != 0) begin
            mean_full   = {batch_sum, 8'd0} / 48'(batch_n);
            rep.mean_q8 = mean_full[31:0];
            n_sumsq = 128'(batch_n) * 128'(batch_sumsq);
            sum_sq  = 128'(batch_sum) * 128'(batch_sum);
            if (n_sumsq >= sum_sq) begin
                // variance in Q16, so its root lands in Q8
                scaled  = (n_sumsq - sum_sq) << 16;
                var_q16 = 64'(scaled / (128'(batch_n) * 128'(batch_n)));
                rep.stddev_q8 = 32'(floor_sqrt(var_q16));
            end
        end
        return rep;
    endfunction

    task automatic absorb_sample(input t_in_item it);
        logic [SAMPLE_BITS-1:0] s;
        s = it.sample_us[SAMPLE_BITS-1:0];
        if (batch_n == COUNT_LIMIT) begin
            batch_dropped = 1'b1;
        end else begin
            batch_n++;
            if (s < batch_min)
                batch_min = s;
            if (s > batch_max)
                batch_max = s;
            batch_sum   += SUM_W'(s);
            batch_sumsq += SUMSQ_W'(s) * SUMSQ_W'(s);
        end
        if (it.last) begin
            expected_reports.push_back(batch_report());
            clear_batch();
        end
    endtask

    task automatic compare_report(input t_out_item got);
        t_out_item want;
        o_reports++;
        if (expected_reports.size() == 0) begin
            flag_mismatch("report with none expected, sample_count",
                          64'(got.sample_count), 64'(0));
        end else begin
            want = expected_reports.pop_front();
            if (got.min_us !== want.min_us)
                flag_mismatch("min_us", 64'(got.min_us), 64'(want.min_us));
            if (got.max_us !== want.max_us)
                flag_mismatch("max_us", 64'(got.max_us), 64'(want.max_us));
            if (got.mean_q8 !== want.mean_q8)
                flag_mismatch("mean_q8", 64'(got.mean_q8), 64'(want.mean_q8));
            if (got.stddev_q8 !== want.stddev_q8)
                flag_mismatch("stddev_q8", 64'(got.stddev_q8), 64'(want.stddev_q8));
            if (got.sample_count !== want.sample_count)
                flag_mismatch("sample_count", 64'(got.sample_count),
                              64'(want.sample_count));
            if (got.overflow !== want.overflow)
                flag_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_batch();
            expected_reports.delete();
        end else begin
            // a report can never belong to an item taken at the same edge
            if (i_out_valid && i_out_ready)
                compare_report(i_out);
            if (i_in_valid && i_in_ready)
                absorb_sample(i_in);
            if (i_end_check && expected_reports.size() != 0) begin
                flag_mismatch("reports never delivered",
                              64'(expected_reports.size()), 64'(0));
                expected_reports.delete();
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

>>> tb/sv/round_trip_statistics_top_tb.sv
`timescale 1ns / 1ps
// Top of the round_trip_statistics_top testbench: clock, reset, sample stimulus,
// receiver back-pressure and verdict. Uses rts_pkg and round_trip_statistics_checker.
module round_trip_statistics_top_tb
    import rts_pkg::*;
();

    localparam int CLK_HI       = 6;
    localparam int CLK_LO       = 6;
    localparam int RESET_CYCLES = 10;
    // Slowest legal gap between handshakes is one report's sequence plus
    // the long receiver hold-off; this is many times that.
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 400;      // settle time after the last report
    localparam int LONG_HOLD    = 1500;     // receiver hold-off, in cycles
    localparam int RANDOM_ITEMS = 1350;
    localparam int MAX_GAP      = 40;

    // Idle profiles, percent of cycles
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 57;
    localparam int IDLE_BOTH  = 13;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      end_check = 1'b0;

    int pending;
    int errors;
    int reports;

    int sender_idle_pct   = IDLE_NONE;
    int receiver_stall_pct = IDLE_NONE;
    bit hold_request      = 1'b0;
    int hold_left         = 0;
    int items_sent        = 0;
    int quiet_cycles      = 0;

    always begin
        #(CLK_LO) clk = 1'b1;
        #(CLK_HI) clk = 1'b0;
    end

    round_trip_statistics_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    round_trip_statistics_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_item),
        .i_end_check (end_check),
        .o_pending   (pending),
        .o_errors    (errors),
        .o_reports   (reports)
    );

    // Receiver: random stalls per the active profile. A hold request from the
    // stimulus loads a long hold-off that this process counts down on its own.
    always @(posedge clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Watchdog: sampled at the falling edge, where both channels are settled
    // and hold the values the next rising edge will see.
    always @(negedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mix of tiny, full-range, near-ceiling and typical round-trip values
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 4))
            0:       return SAMPLE_W'($urandom_range(0, 15));
            1:       return {SAMPLE_W{1'b1}} - SAMPLE_W'($urandom_range(0, 15));
            2:       return SAMPLE_W'($urandom_range(0, 100000));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Called at a rising edge; returns at the rising edge that took the item.
    // Ready is read at the falling edge before, where it is already settled.
    task automatic offer_sample(input logic [SAMPLE_W-1:0] sample, input logic last);
        int   gap;
        logic ready_seen;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= '{sample_us: sample, last: last};
        in_valid <= 1'b1;
        ready_seen = 1'b0;
        while (!ready_seen) begin
            @(negedge clk);
            ready_seen = in_ready;
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_batch(input int len);
        for (int i = 0; i < len; i++)
            offer_sample(pick_sample(), i == len - 1);
    endtask

    // Sender stops offering until every expected report has come back
    task automatic drain_reports();
        in_valid <= 1'b0;
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    initial begin
        int phase_items;
        int len;
        bit hold_done;
        hold_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: single-sample batches at both extremes, a zero/full spread,
        // identical samples (zero deviation), a small ramp, mid-scale bits and a tight cluster.
        offer_sample('0, 1'b1);
        offer_sample('1, 1'b1);
        offer_sample('0, 1'b0);
        offer_sample('1, 1'b1);
        offer_sample(SAMPLE_W'(5), 1'b0);
        offer_sample(SAMPLE_W'(5), 1'b0);
        offer_sample(SAMPLE_W'(5), 1'b1);
        for (int i = 1; i <= 4; i++)
            offer_sample(SAMPLE_W'(i), i == 4);
        offer_sample(SAMPLE_W'(24'h800000), 1'b0);
        offer_sample(SAMPLE_W'(24'h7FFFFF), 1'b0);
        offer_sample(SAMPLE_W'(24'h555555), 1'b0);
        offer_sample(SAMPLE_W'(24'hAAAAAA), 1'b1);
        offer_sample(SAMPLE_W'(1000), 1'b0);
        offer_sample(SAMPLE_W'(1001), 1'b0);
        offer_sample(SAMPLE_W'(999), 1'b1);
        drain_reports();

        // Random batches under each idle profile
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct    = IDLE_NONE;
                    receiver_stall_pct = IDLE_NONE;
                end
                1: begin
                    sender_idle_pct    = IDLE_HEAVY;
                    receiver_stall_pct = IDLE_NONE;
                end
                2: begin
                    sender_idle_pct    = IDLE_NONE;
                    receiver_stall_pct = IDLE_HEAVY;
                end
                default: begin
                    sender_idle_pct    = IDLE_BOTH;
                    receiver_stall_pct = IDLE_BOTH;
                end
            endcase
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / 4) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
                send_batch(len);
                phase_items += len;
                // Long receiver hold-off with short batches behind it: the
                // output register fills and the input has to stall.
                if (ph == 0 && !hold_done && phase_items > 100) begin
                    hold_request = 1'b1;
                    for (int k = 0; k < 12; k++) begin
                        len = $urandom_range(1, 3);
                        send_batch(len);
                        phase_items += len;
                    end
                    hold_done = 1'b1;
                end
            end
            drain_reports();
        end

        // End of stimulus: wait for the last report, then let the block settle
        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);
        end_check <= 1'b1;
        @(posedge clk);
        end_check <= 1'b0;
        @(negedge clk);

        $display("Sent %0d samples and checked %0d batch reports over four idle profiles,",
                 items_sent, reports);
        $display("plus a long receiver hold-off that backed up the input.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> round_trip_statistics_top.f
rtl/rts_pkg.sv
rtl/round_trip_statistics_top.sv
tb/sv/round_trip_statistics_checker.sv
tb/sv/round_trip_statistics_top_tb.sv
